[src/aidr_pkg.sv]
// Shared types and codes for the id allocator: request kinds, status codes,
// controller states and the command/status bundles between ctrl and datapath.
// No dependencies.
`default_nettype none

package aidr_pkg;

    // request kinds
    localparam logic [2:0] KIND_GEN     = 3'd0;
    localparam logic [2:0] KIND_QUERY   = 3'd1;
    localparam logic [2:0] KIND_CLAIM   = 3'd2;
    localparam logic [2:0] KIND_RECYCLE = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GEN_RD,
        ST_GEN_CAP,
        ST_SEARCH,
        ST_FILL,
        ST_SHIFT,
        ST_RESP
    } aidr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch request
        logic gen_first;    // first id since reset or clear: 0
        logic gen_inc;      // highest plus one
        logic gen_exhaust;  // id space used up
        logic mem_rd0;      // read list head
        logic gen_pop;      // take head data as new id
        logic assign_set;   // query answer 1
        logic scan_start;   // walk from entry 0
        logic walk;         // one step of the list walk
        logic shift_wr;     // write back one entry during removal
        logic shift_start;  // removal starts after matched entry
        logic shift_done;   // list shrinks by one
        logic claim_start;  // claim bookkeeping
        logic fill_push;    // push one skipped id
        logic set_full;     // flag dropped ids
        logic recycle;      // push request id
        logic clear_all;    // forget everything
        logic out_load;     // load result register
    } aidr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] kind;
        logic       count_zero;
        logic       full;
        logic       id_above;    // no id issued, or id above highest
        logic       none_issued; // no id issued since reset or clear
        logic       latest_hit;
        logic       exhausted;
        logic       scan_more;   // walk pointer below fill count
        logic       pend;        // read data in flight
        logic       match;
        logic       fill_more;
    } aidr_sts_t;

endpackage

`default_nettype wire

[src/id_allocator_with_recycle_list.sv]
// Top level of the id allocator with a FIFO recycle list.
// Depends on aidr_pkg, aidr_ctrl and aidr_dp.
`default_nettype none

//  channel   handshake              payload
//  request   in_valid / in_stall    kind[2:0], id[15:0]
//  result    out_valid / out_stall  new_id, is_assigned, latest_valid, latest_id,
//                                   highest_valid, highest_id, status
//
//  One request at a time; each request gives exactly one result.
//  Recycle, clear, unused kinds, generate with an empty list and direct query
//  answers pass through accept, dispatch and result load only; a list walk
//  (query, claim search, generate from the list, removal) adds a step per
//  list entry, and a claim past the highest id adds a step per skipped id,
//  up to FREE_DEPTH. These steps are paced by the single read port and
//  single write port of the free-list memory.
//  Reset is asynchronous; the list store itself is never cleared (the fill
//  count guards it), so requests are taken right after reset.
//  A stalled result sits in the output register while the next request is
//  taken and worked on; only its final load waits for the register.

module id_allocator_with_recycle_list
    import aidr_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int FREE_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      new_id,
    output logic             is_assigned,
    output logic             latest_valid,
    output logic [15:0]      latest_id,
    output logic             highest_valid,
    output logic [15:0]      highest_id,
    output logic [1:0]       status
);

    aidr_cmd_t cmd;
    aidr_sts_t sts;

    // sequencing: decode, list walks, fill and result hand-off
    aidr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // id registers, free-list memory and result register
    aidr_dp #(
        .ID_BITS    (ID_BITS),
        .FREE_DEPTH (FREE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .id            (id),
        .cmd           (cmd),
        .sts           (sts),
        .new_id        (new_id),
        .is_assigned   (is_assigned),
        .latest_valid  (latest_valid),
        .latest_id     (latest_id),
        .highest_valid (highest_valid),
        .highest_id    (highest_id),
        .status        (status)
    );

`ifndef SYNTHESIS
    // a taken request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous one in flight");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("result register overwritten");

    // a skipped id is only pushed while the list has room
    a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_push |-> !sts.full)
        else $error("push into full free list");

    // a new result appears only after a load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result valid without load");
`endif

endmodule

`default_nettype wire

[src/aidr_ctrl.sv]
// Controller state machine for the id allocator.
// Depends on aidr_pkg; drives aidr_dp through aidr_cmd_t.
`default_nettype none

module aidr_ctrl
    import aidr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire aidr_sts_t sts,
    output aidr_cmd_t      cmd
);

    aidr_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                state_next = ST_RESP;
                case (sts.kind)
                    KIND_GEN:
                    begin
                        // list head first; with an empty list: first id,
                        // next id or exhausted
                        if (!sts.count_zero)
                            state_next = ST_GEN_RD;
                        else if (sts.none_issued)
                            cmd.gen_first = 1'b1;
                        else if (sts.exhausted)
                            cmd.gen_exhaust = 1'b1;
                        else
                            cmd.gen_inc = 1'b1;
                    end
                    KIND_QUERY:
                    begin
                        if (sts.latest_hit)
                            cmd.assign_set = 1'b1;
                        else if (!sts.id_above)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SEARCH;
                        end
                    end
                    KIND_CLAIM:
                    begin
                        cmd.claim_start = 1'b1;
                        if (sts.id_above)
                            state_next = ST_FILL;
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SEARCH;
                        end
                    end
                    KIND_RECYCLE: cmd.recycle   = 1'b1;
                    KIND_CLEAR:   cmd.clear_all = 1'b1;
                    default:      state_next    = ST_RESP;
                endcase
            end

            ST_GEN_RD:
            begin
                cmd.mem_rd0 = 1'b1;
                state_next  = ST_GEN_CAP;
            end

            ST_GEN_CAP:
            begin
                cmd.gen_pop = 1'b1;
                state_next  = ST_SHIFT;
            end

            ST_SEARCH:
            begin
                if (sts.match)
                begin
                    if (sts.kind == KIND_CLAIM)
                    begin
                        cmd.shift_start = 1'b1;
                        state_next      = ST_SHIFT;
                    end
                    else
                        state_next = ST_RESP;
                end
                else if (!sts.pend && !sts.scan_more)
                begin
                    // not on the list
                    if (sts.kind == KIND_QUERY)
                        cmd.assign_set = 1'b1;
                    state_next = ST_RESP;
                end
                else
                    cmd.walk = 1'b1;
            end

            ST_FILL:
            begin
                if (sts.fill_more && !sts.full)
                    cmd.fill_push = 1'b1;
                else
                begin
                    cmd.set_full = sts.fill_more;
                    state_next   = ST_RESP;
                end
            end

            ST_SHIFT:
            begin
                if (!sts.pend && !sts.scan_more)
                begin
                    cmd.shift_done = 1'b1;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cmd.walk     = 1'b1;
                    cmd.shift_wr = 1'b1;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[src/aidr_dp.sv]
// Datapath for the id allocator: free-list memory, id registers, list walk
// and result register. Depends on aidr_pkg; driven by aidr_ctrl.
`default_nettype none

module aidr_dp
    import aidr_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int FREE_DEPTH = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] id,
    input  wire aidr_cmd_t   cmd,
    output aidr_sts_t        sts,
    output logic [15:0]      new_id,
    output logic             is_assigned,
    output logic             latest_valid,
    output logic [15:0]      latest_id,
    output logic             highest_valid,
    output logic [15:0]      highest_id,
    output logic [1:0]       status
);

    localparam int AW = $clog2(FREE_DEPTH);
    localparam int CW = $clog2(FREE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FREE_DEPTH);

    // free list store, entry 0 oldest
    logic [ID_BITS-1:0] free_ids_mem [FREE_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [ID_BITS-1:0] wr_data;

    // control state
    logic [CW-1:0]      count_reg;
    logic [ID_BITS-1:0] latest_reg, highest_reg;
    logic               latest_known_reg, highest_known_reg;
    logic               pend_reg;

    // request and walk payload
    logic [2:0]         kind_reg;
    logic [ID_BITS-1:0] id_reg, w_reg, res_id_reg;
    logic [CW-1:0]      ptr_reg;
    logic [AW-1:0]      pend_addr_reg;
    logic               assigned_reg;
    logic [1:0]         status_reg;

    // result register
    logic [15:0]        out_new_id_reg, out_latest_id_reg, out_highest_id_reg;
    logic               out_assigned_reg, out_latest_valid_reg, out_highest_valid_reg;
    logic [1:0]         out_status_reg;

    always_comb
    begin
        sts.kind        = kind_reg;
        sts.count_zero  = (count_reg == '0);
        sts.full        = (count_reg == DEPTH_C);
        sts.id_above    = !highest_known_reg || (id_reg > highest_reg);
        sts.none_issued = !highest_known_reg;
        sts.latest_hit  = latest_known_reg && (id_reg == latest_reg);
        sts.exhausted   = &highest_reg;
        sts.scan_more   = (ptr_reg < count_reg);
        sts.pend        = pend_reg;
        sts.match       = pend_reg && (rd_data_reg == id_reg);
        sts.fill_more   = (w_reg < id_reg);
    end

    // memory port muxing
    always_comb
    begin
        rd_en   = cmd.mem_rd0 || (cmd.walk && sts.scan_more);
        rd_addr = cmd.mem_rd0 ? '0 : ptr_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = w_reg;
        if (cmd.fill_push)
            wr_en = 1'b1;
        else if (cmd.recycle && !sts.full)
        begin
            wr_en   = 1'b1;
            wr_data = id_reg;
        end
        else if (cmd.shift_wr && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg - 1'b1;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            free_ids_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= free_ids_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            latest_reg        <= '0;
            latest_known_reg  <= 1'b0;
            highest_reg       <= '0;
            highest_known_reg <= 1'b0;
            pend_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.gen_first)
            begin
                highest_reg       <= '0;
                highest_known_reg <= 1'b1;
                latest_reg        <= '0;
                latest_known_reg  <= 1'b1;
            end
            if (cmd.gen_inc)
            begin
                highest_reg      <= highest_reg + 1'b1;
                latest_reg       <= highest_reg + 1'b1;
                latest_known_reg <= 1'b1;
            end
            if (cmd.gen_pop)
            begin
                latest_reg       <= rd_data_reg;
                latest_known_reg <= 1'b1;
            end
            if (cmd.claim_start)
            begin
                latest_reg       <= id_reg;
                latest_known_reg <= 1'b1;
                if (sts.id_above)
                begin
                    highest_reg       <= id_reg;
                    highest_known_reg <= 1'b1;
                end
            end
            if (cmd.recycle)
            begin
                if (!sts.full)
                    count_reg <= count_reg + 1'b1;
                if (sts.latest_hit)
                begin
                    latest_reg       <= '0;
                    latest_known_reg <= 1'b0;
                end
            end
            if (cmd.fill_push)
                count_reg <= count_reg + 1'b1;
            if (cmd.shift_done)
                count_reg <= count_reg - 1'b1;
            if (cmd.clear_all)
            begin
                count_reg         <= '0;
                latest_reg        <= '0;
                latest_known_reg  <= 1'b0;
                highest_reg       <= '0;
                highest_known_reg <= 1'b0;
            end

            if (cmd.scan_start || cmd.gen_pop || cmd.shift_start)
                pend_reg <= 1'b0;
            else if (cmd.walk)
                pend_reg <= sts.scan_more;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg     <= kind;
            id_reg       <= ID_BITS'(id);
            res_id_reg   <= '0;
            assigned_reg <= 1'b0;
            status_reg   <= STATUS_OK;
        end
        if (cmd.gen_inc)
            res_id_reg <= highest_reg + 1'b1;
        if (cmd.gen_pop)
        begin
            res_id_reg <= rd_data_reg;
            ptr_reg    <= CW'(1);
        end
        if (cmd.gen_exhaust)
            status_reg <= STATUS_EXHAUSTED;
        if (cmd.set_full || (cmd.recycle && sts.full))
            status_reg <= STATUS_FULL;
        if (cmd.assign_set)
            assigned_reg <= 1'b1;
        if (cmd.claim_start && sts.id_above)
            w_reg <= highest_known_reg ? highest_reg + 1'b1 : '0;
        if (cmd.fill_push)
            w_reg <= w_reg + 1'b1;
        if (cmd.scan_start)
            ptr_reg <= '0;
        if (cmd.shift_start)
            ptr_reg <= CW'(pend_addr_reg) + 1'b1;
        if (cmd.walk && sts.scan_more)
        begin
            ptr_reg       <= ptr_reg + 1'b1;
            pend_addr_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.out_load)
        begin
            out_new_id_reg        <= 16'(res_id_reg);
            out_assigned_reg      <= assigned_reg;
            out_latest_valid_reg  <= latest_known_reg;
            out_latest_id_reg     <= latest_known_reg ? 16'(latest_reg) : 16'd0;
            out_highest_valid_reg <= highest_known_reg;
            out_highest_id_reg    <= highest_known_reg ? 16'(highest_reg) : 16'd0;
            out_status_reg        <= status_reg;
        end
    end

    assign new_id        = out_new_id_reg;
    assign is_assigned   = out_assigned_reg;
    assign latest_valid  = out_latest_valid_reg;
    assign latest_id     = out_latest_id_reg;
    assign highest_valid = out_highest_valid_reg;
    assign highest_id    = out_highest_id_reg;
    assign status        = out_status_reg;

endmodule

`default_nettype wire
